// ----- hdl/lru_pkg.sv -----
// Shared types and constants for the LRU page replacement unit.
// No dependencies. Used by the output channel interface, the controller, the datapath and the top level.
package lru_pkg;

  localparam int FAULT_BITS = 32;
  localparam logic [FAULT_BITS-1:0] FAULT_MAX = {FAULT_BITS{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE
  } lru_state_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;    // latch incoming page
    logic match;   // register compare results and victim
    logic update;  // write frames, fault count and result registers
  } lru_cmd_t;

endpackage

// ----- hdl/lru_chan_if.sv -----
// Valid/ready channel interfaces for page references and lookup results.
// Depends on lru_pkg for the fault counter width.
interface lru_in_if #(
  parameter int PAGE_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

interface lru_out_if
  import lru_pkg::*;
#(
  parameter int PAGE_BITS = 16,
  parameter int IDX_W     = 2
);
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [IDX_W-1:0]      frame_index;
  logic                  evicted_valid;
  logic [PAGE_BITS-1:0]  evicted_page;
  logic [FAULT_BITS-1:0] fault_total;

  modport source (output valid, output hit, output frame_index, output evicted_valid,
                  output evicted_page, output fault_total, input ready);
  modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                  input evicted_page, input fault_total, output ready);
endinterface

// ----- hdl/lru_ctrl.sv -----
// Sequencing state machine for the LRU unit: accept, compare, update.
// Depends on lru_pkg (state enum, command struct).
module lru_ctrl
  import lru_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output lru_cmd_t cmd
);

  lru_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       update_go;
  logic       accept;

  // update may proceed once the result register is free or being drained
  assign update_go = (state_r == ST_UPDATE) && (!out_valid_r || out_ready);
  assign in_ready  = (state_r == ST_IDLE) || update_go;
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_MATCH;
      end
      ST_MATCH: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (update_go) state_nxt = accept ? ST_MATCH : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.load   = accept;
    cmd.match  = (state_r == ST_MATCH);
    cmd.update = update_go;
    if (update_go)      out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_match_then_update: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MATCH |=> state_r == ST_UPDATE)
    else $error("compare cycle not followed by update");

  a_no_accept_in_match: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MATCH |-> !in_ready)
    else $error("item taken during compare cycle");

  a_update_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> out_valid_r)
    else $error("update did not present a result");

endmodule

// ----- hdl/lru_dpath.sv -----
// Frame table, compare, victim select and result registers for the LRU unit.
// Depends on lru_pkg (command struct, fault counter constants).
module lru_dpath
  import lru_pkg::*;
#(
  parameter int FRAME_COUNT = 4,
  parameter int PAGE_BITS   = 16,
  parameter int AGE_BITS    = 8,
  parameter int IDX_W       = 2
)(
  input  logic                  clk,
  input  logic                  rst_n,
  input  lru_cmd_t              cmd,
  input  logic [PAGE_BITS-1:0]  in_page,
  output logic                  out_hit,
  output logic [IDX_W-1:0]      out_frame_index,
  output logic                  out_evicted_valid,
  output logic [PAGE_BITS-1:0]  out_evicted_page,
  output logic [FAULT_BITS-1:0] out_fault_total
);

  localparam int NODES = 1 << IDX_W;
  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  // frame table
  logic [FRAME_COUNT-1:0] slot_valid_r, slot_valid_nxt;
  logic [PAGE_BITS-1:0]   slot_page_r [FRAME_COUNT];
  logic [PAGE_BITS-1:0]   slot_page_nxt [FRAME_COUNT];
  logic [AGE_BITS-1:0]    slot_age_r [FRAME_COUNT];
  logic [AGE_BITS-1:0]    slot_age_nxt [FRAME_COUNT];
  logic [FAULT_BITS-1:0]  fault_count_r, fault_count_nxt;

  // compare stage registers
  logic [PAGE_BITS-1:0]   page_r;
  logic [FRAME_COUNT-1:0] match_r, match_c;
  logic                   hit_r;
  logic [IDX_W-1:0]       hit_idx_r, hit_idx_c;
  logic                   empty_ok_r, empty_ok_c;
  logic [IDX_W-1:0]       empty_idx_r, empty_idx_c;
  logic [IDX_W-1:0]       victim_r;

  // result registers
  logic                   res_hit_r;
  logic [IDX_W-1:0]       res_idx_r;
  logic                   res_ev_valid_r;
  logic [PAGE_BITS-1:0]   res_ev_page_r;

  logic [AGE_BITS-1:0]    age_inc [FRAME_COUNT];

  // max-age tournament tree, ties to the left (lower index)
  logic [AGE_BITS-1:0]    t_age [IDX_W+1][NODES];
  logic [IDX_W-1:0]       t_idx [IDX_W+1][NODES];
  logic                   t_ok  [IDX_W+1][NODES];

  logic [IDX_W-1:0]       where_c;
  logic                   evict_c;

  always_comb begin
    for (int i = 0; i < FRAME_COUNT; i++) begin
      age_inc[i] = (slot_age_r[i] == AGE_MAX) ? slot_age_r[i] : slot_age_r[i] + 1'b1;
      match_c[i] = slot_valid_r[i] && (slot_page_r[i] == page_r);
    end
  end

  // lowest-index hit and lowest-index empty frame
  always_comb begin
    hit_idx_c   = '0;
    empty_ok_c  = 1'b0;
    empty_idx_c = '0;
    for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
      if (match_c[i]) hit_idx_c = IDX_W'(i);
      if (!slot_valid_r[i]) begin
        empty_ok_c  = 1'b1;
        empty_idx_c = IDX_W'(i);
      end
    end
  end

  always_comb begin
    for (int l = 0; l <= IDX_W; l++) begin
      for (int j = 0; j < NODES; j++) begin
        t_age[l][j] = '0;
        t_idx[l][j] = '0;
        t_ok[l][j]  = 1'b0;
      end
    end
    for (int j = 0; j < FRAME_COUNT; j++) begin
      t_age[0][j] = age_inc[j];
      t_idx[0][j] = IDX_W'(j);
      t_ok[0][j]  = slot_valid_r[j];
    end
    for (int l = 0; l < IDX_W; l++) begin
      for (int j = 0; j < NODES / 2; j++) begin
        if (j < (NODES >> (l + 1))) begin
          if (t_ok[l][2*j+1] && (!t_ok[l][2*j] || t_age[l][2*j+1] > t_age[l][2*j])) begin
            t_age[l+1][j] = t_age[l][2*j+1];
            t_idx[l+1][j] = t_idx[l][2*j+1];
          end else begin
            t_age[l+1][j] = t_age[l][2*j];
            t_idx[l+1][j] = t_idx[l][2*j];
          end
          t_ok[l+1][j] = t_ok[l][2*j] || t_ok[l][2*j+1];
        end
      end
    end
  end

  // update: age, fill or replace
  always_comb begin
    evict_c = !hit_r && !empty_ok_r;
    if (hit_r)           where_c = hit_idx_r;
    else if (empty_ok_r) where_c = empty_idx_r;
    else                 where_c = victim_r;

    slot_valid_nxt = slot_valid_r;
    for (int i = 0; i < FRAME_COUNT; i++) begin
      slot_page_nxt[i] = slot_page_r[i];
      if (!slot_valid_r[i])  slot_age_nxt[i] = slot_age_r[i];
      else if (match_r[i])   slot_age_nxt[i] = '0;
      else                   slot_age_nxt[i] = age_inc[i];
    end
    fault_count_nxt = fault_count_r;
    if (!hit_r) begin
      slot_valid_nxt[where_c] = 1'b1;
      slot_page_nxt[where_c]  = page_r;
      slot_age_nxt[where_c]   = '0;
      if (fault_count_r != FAULT_MAX) fault_count_nxt = fault_count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r  <= '0;
      fault_count_r <= '0;
    end else if (cmd.update) begin
      slot_valid_r  <= slot_valid_nxt;
      fault_count_r <= fault_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) page_r <= in_page;
    if (cmd.match) begin
      match_r     <= match_c;
      hit_r       <= |match_c;
      hit_idx_r   <= hit_idx_c;
      empty_ok_r  <= empty_ok_c;
      empty_idx_r <= empty_idx_c;
      victim_r    <= t_idx[IDX_W][0];
    end
    if (cmd.update) begin
      for (int i = 0; i < FRAME_COUNT; i++) begin
        slot_page_r[i] <= slot_page_nxt[i];
        slot_age_r[i]  <= slot_age_nxt[i];
      end
      res_hit_r      <= hit_r;
      res_idx_r      <= where_c;
      res_ev_valid_r <= evict_c;
      res_ev_page_r  <= evict_c ? slot_page_r[victim_r] : '0;
    end
  end

  assign out_hit           = res_hit_r;
  assign out_frame_index   = res_idx_r;
  assign out_evicted_valid = res_ev_valid_r;
  assign out_evicted_page  = res_ev_page_r;
  assign out_fault_total   = fault_count_r;

  a_frame_resident: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> slot_valid_r[res_idx_r] && slot_page_r[res_idx_r] == $past(page_r))
    else $error("reported frame does not hold the referenced page");

  a_fault_counted: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update && !hit_r |=> fault_count_r != '0)
    else $error("miss left fault count at zero");

  a_evict_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update && evict_c |-> &slot_valid_r)
    else $error("eviction while an empty frame exists");

endmodule

// ----- hdl/lru_page_replacement_unit.sv -----
// LRU page replacement unit: each item passes the compare state (parallel
// compare and victim tree), then the update state, on a shared frame table.
// The update loads the result registers, and waits while a result is unread.
// A new item is taken in the update cycle once it proceeds, not in compare.
// Reset (rst_n low, synchronous): all frames empty, fault count zero, no result.
// Depends on lru_pkg, lru_chan_if, lru_ctrl and lru_dpath.
module lru_page_replacement_unit
  import lru_pkg::*;
#(
  parameter int FRAME_COUNT = 4,
  parameter int PAGE_BITS   = 16,
  parameter int AGE_BITS    = 8
)(
  input logic         clk,
  input logic         rst_n,
  lru_in_if.sink      in_ch,
  lru_out_if.source   out_ch
);

  localparam int IDX_W = $clog2(FRAME_COUNT);

  lru_cmd_t cmd;

  // Controller: sequences accept -> compare -> update and owns the result
  // valid flag, so a waiting result never blocks the next item's compare.
  lru_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // Datapath: frame table with per-frame age counters, hit/empty priority
  // encoders, max-age tree for the victim, fault counter, result registers.
  lru_dpath #(
    .FRAME_COUNT (FRAME_COUNT),
    .PAGE_BITS   (PAGE_BITS),
    .AGE_BITS    (AGE_BITS),
    .IDX_W       (IDX_W)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_page           (in_ch.page_number),
    .out_hit           (out_ch.hit),
    .out_frame_index   (out_ch.frame_index),
    .out_evicted_valid (out_ch.evicted_valid),
    .out_evicted_page  (out_ch.evicted_page),
    .out_fault_total   (out_ch.fault_total)
  );

endmodule
